/* sv/tccb_pkg.sv */
`timescale 1ns / 1ps

package tccb_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [6:0] RST_ROWS    = 7'd25;

    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
    localparam logic [12:0] LINE_MAX     = 13'd8191;

    localparam logic [1:0] FUNC_PUT       = 2'd0;
    localparam logic [1:0] FUNC_BACKSPACE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR     = 2'd2;
    localparam logic [1:0] FUNC_READ      = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [12:0] cell_index;
    } t_in;

    typedef struct packed {
        logic [7:0]  read_char;
        logic [12:0] cursor_position;
        logic        scrolled;
    } t_out;

    typedef enum logic [2:0] {
        S_SETTLE,
        S_CLEAR,
        S_SCROLL,
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic home;
        logic exec_put;
        logic exec_bs;
        logic ptr_clr;
        logic sweep;
        logic scroll;
        logic load_res;
        logic res_read;
        logic res_scrolled;
    } t_cmd;

    typedef struct packed {
        logic need_scroll;
        logic sweep_last;
        logic cfg_hit;
    } t_status;

endpackage

/* sv/tccb_ctrl.sv */
`timescale 1ns / 1ps

module tccb_ctrl import tccb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;
    logic   r_report, n_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SETTLE;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        o_cmd    = '0;
        o_busy   = 1'b1;
        case (r_state)
            S_SETTLE: begin
                o_cmd.ptr_clr = 1'b1;
                n_state       = S_CLEAR;
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.load_res = r_report;
                    n_report       = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            S_SCROLL: begin
                o_cmd.sweep  = 1'b1;
                o_cmd.scroll = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.load_res     = 1'b1;
                    o_cmd.res_scrolled = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    case (i_func)
                        FUNC_PUT: begin
                            o_cmd.exec_put = 1'b1;
                            if (i_status.need_scroll) begin
                                o_cmd.ptr_clr = 1'b1;
                                n_state       = S_SCROLL;
                            end else begin
                                o_cmd.load_res = 1'b1;
                            end
                        end
                        FUNC_BACKSPACE: begin
                            o_cmd.exec_bs  = 1'b1;
                            o_cmd.load_res = 1'b1;
                        end
                        FUNC_CLEAR: begin
                            o_cmd.home    = 1'b1;
                            o_cmd.ptr_clr = 1'b1;
                            n_report      = 1'b1;
                            n_state       = S_CLEAR;
                        end
                        default: begin
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.load_res = 1'b1;
                o_cmd.res_read = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_SETTLE;
            end
        endcase
        // a resize blanks everything and restarts the clearing sweep
        if (i_status.cfg_hit) begin
            o_cmd    = '0;
            o_cmd.home = 1'b1;
            n_report = 1'b0;
            n_state  = S_SETTLE;
        end
    end

endmodule

/* sv/tccb_datapath.sv */
`timescale 1ns / 1ps

module tccb_datapath import tccb_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_in                   i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_status               o_status,
    output t_out                  o_result,
    output logic                  o_done
);

    localparam int STORE  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(STORE);
    localparam int TOT_W  = $clog2(STORE + 1);
    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CMP_W  = TOT_W + 13;

    logic [7:0]        r_cols_cfg;
    logic [6:0]        r_rows_cfg;
    logic [COL_W-1:0]  cols_use;
    logic [ROW_W-1:0]  rows_use;
    logic [TOT_W-1:0]  r_total;
    logic [TOT_W-1:0]  cols_t;
    logic [TOT_W-1:0]  blank_base;

    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col, n_col;
    logic [12:0]       r_line, n_line;
    logic [TOT_W-1:0]  r_ptr;

    logic [7:0]        r_mem [STORE];
    logic [7:0]        r_rd_data;
    logic              r_in_range;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_wdata;

    logic [TOT_W-1:0]  cur_t;
    logic [TOT_W-1:0]  put_cursor;
    logic [COL_W-1:0]  put_col;
    logic [COL_W-1:0]  col_inc;
    logic [TOT_W-1:0]  sweep_idx;
    logic              is_newline;
    logic              bs_ok;
    logic              cfg_hit;

    t_out              r_res;
    logic              r_done;

    // register file
    assign cfg_hit = i_cfg_we && (i_cfg_idx == REG_COLUMNS || i_cfg_idx == REG_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= RST_COLUMNS;
            r_rows_cfg <= RST_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COLUMNS: r_cols_cfg <= i_cfg_data;
                REG_ROWS:    r_rows_cfg <= i_cfg_data[6:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        if (r_cols_cfg == 8'd0) begin
            cols_use = COL_W'(1);
        end else if (int'(r_cols_cfg) > MAX_COLUMNS) begin
            cols_use = COL_W'(MAX_COLUMNS);
        end else begin
            cols_use = COL_W'(r_cols_cfg);
        end
        if (r_rows_cfg == 7'd0) begin
            rows_use = ROW_W'(1);
        end else if (int'(r_rows_cfg) > MAX_ROWS) begin
            rows_use = ROW_W'(MAX_ROWS);
        end else begin
            rows_use = ROW_W'(r_rows_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= TOT_W'(TOT_W'(cols_use) * TOT_W'(rows_use));
    end

    assign cols_t     = TOT_W'(cols_use);
    assign blank_base = r_total - cols_t;

    // cursor update
    assign cur_t      = TOT_W'(r_cursor);
    assign is_newline = (i_item.char_code == CHAR_NEWLINE);
    assign col_inc    = (r_col + COL_W'(1) == cols_use) ? '0 : r_col + COL_W'(1);
    assign put_cursor = is_newline ? cur_t + (cols_t - TOT_W'(r_col)) : cur_t + TOT_W'(1);
    assign put_col    = is_newline ? '0 : col_inc;
    assign bs_ok      = (r_line != 13'd0) && (r_cursor != '0);

    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        n_line   = r_line;
        if (i_cmd.home) begin
            n_cursor = '0;
            n_col    = '0;
        end else if (i_cmd.exec_put) begin
            if (is_newline) begin
                n_line = 13'd0;
            end else if (r_line != LINE_MAX) begin
                n_line = r_line + 13'd1;
            end
            if (put_cursor >= r_total) begin
                // scroll leaves the cursor at the start of the bottom row
                n_cursor = ADDR_W'(blank_base);
                n_col    = '0;
            end else begin
                n_cursor = ADDR_W'(put_cursor);
                n_col    = put_col;
            end
        end else if (i_cmd.exec_bs && bs_ok) begin
            n_line   = r_line - 13'd1;
            n_cursor = r_cursor - ADDR_W'(1);
            n_col    = (r_col == '0) ? cols_use - COL_W'(1) : r_col - COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
            r_line   <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_line   <= n_line;
        end
    end

    // sweep counter: writes cell ptr-1, prefetches cell ptr+cols for a scroll
    always_ff @(posedge i_clk) begin
        if (i_cmd.ptr_clr) begin
            r_ptr <= '0;
        end else if (i_cmd.sweep) begin
            r_ptr <= r_ptr + TOT_W'(1);
        end
    end

    assign sweep_idx = r_ptr - TOT_W'(1);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cursor;
        mem_wdata = i_item.char_code;
        mem_raddr = ADDR_W'(i_item.cell_index);
        if (i_cmd.sweep) begin
            mem_we    = (r_ptr != '0);
            mem_waddr = ADDR_W'(sweep_idx);
            mem_wdata = (i_cmd.scroll && sweep_idx < blank_base) ? r_rd_data : CHAR_SPACE;
            mem_raddr = ADDR_W'(r_ptr + cols_t);
        end else if (i_cmd.exec_put) begin
            mem_we = !is_newline;
        end else if (i_cmd.exec_bs) begin
            mem_we    = bs_ok;
            mem_waddr = r_cursor - ADDR_W'(1);
            mem_wdata = CHAR_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data  <= r_mem[mem_raddr];
        r_in_range <= CMP_W'(i_item.cell_index) < CMP_W'(r_total);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_res.read_char       <= i_cmd.res_read ? (r_in_range ? r_rd_data : CHAR_SPACE)
                                                    : 8'h00;
            r_res.cursor_position <= 13'(n_cursor);
            r_res.scrolled        <= i_cmd.res_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.load_res;
        end
    end

    assign o_status.need_scroll = (put_cursor >= r_total);
    assign o_status.sweep_last  = (r_ptr == r_total);
    assign o_status.cfg_hit     = cfg_hit;
    assign o_result             = r_res;
    assign o_done               = r_done;

endmodule

/* sv/text_console_cell_buffer_top.sv */
`timescale 1ns / 1ps
// Put (no scroll), backspace: result strobed the next cycle, next item the same cycle.
// Read: goes through S_READ, which loads the result from the registered store read.
// Clear and scroll: one sweep over the store port, result on the next cycle.
// Reset (synchronous) and any columns/rows write: busy in S_SETTLE and a sweep while
// the cells in use are filled with spaces; o_done is a one-cycle strobe, never stalled.

module text_console_cell_buffer_top import tccb_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in                   i_cmd,
    output logic                  o_done,
    output t_out                  o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    tccb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_func   (i_cmd.func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    tccb_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    a_bs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_cfg_we && i_cmd.func == FUNC_BACKSPACE) |=> o_done)
        else $error("backspace transfer without result on the next cycle");

    a_char_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.read_char != 8'h00) |-> $past(cmd.res_read))
        else $error("nonzero read_char on a non-read result");

    a_scroll_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.scrolled) |-> $past(cmd.scroll && cmd.sweep))
        else $error("scrolled result without a finished scroll sweep");

    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sweep |-> o_busy)
        else $error("store sweep while accepting transfers");

endmodule

/* tb/text_console_cell_buffer_top_tb.sv */
`timescale 1ns / 1ps

module text_console_cell_buffer_top_tb;
    import tccb_pkg::*;

    localparam int CELL_COUNT  = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
    localparam int CYCLE_LIMIT = 1_000_000;

    // indexes past the register list, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_start    = 1'b0;
    t_in                   i_cmd      = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_busy;
    logic                  o_done;
    t_out                  o_result;

    text_console_cell_buffer_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the console
    logic [7:0]  shadow_cells [0:CELL_COUNT-1];
    int unsigned shadow_cursor;
    int unsigned typed_count;
    logic [7:0]  columns_reg;
    logic [6:0]  rows_reg;

    t_in  cmd_q [$];
    t_out expected_q [$];

    bit no_gaps     = 1'b0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_scrolls   = 0;
    int n_reads     = 0;
    int n_reg_wr    = 0;
    int n_fail      = 0;
    int cycle_count = 0;

    function automatic int unsigned eff_columns();
        if (columns_reg == 0) return 1;
        if (columns_reg > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
        return 32'(columns_reg);
    endfunction

    function automatic int unsigned eff_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return 32'(rows_reg);
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = CHAR_SPACE;
        shadow_cursor = 0;
    endfunction

    // resize blanks the store; unknown indexes do nothing
    function automatic void console_write_reg(logic [CFG_IDX_W-1:0] idx,
                                              logic [CFG_DATA_W-1:0] data);
        if (idx == REG_COLUMNS) begin
            columns_reg = data;
        end else if (idx == REG_ROWS) begin
            rows_reg = data[6:0];
        end else begin
            return;
        end
        blank_screen();
    endfunction

    function automatic t_out console_step(t_in c);
        int unsigned cols;
        int unsigned nrows;
        int unsigned total;
        t_out r;
        cols  = eff_columns();
        nrows = eff_rows();
        total = cols * nrows;
        r     = '0;
        if (shadow_cursor >= total) shadow_cursor = 0;
        case (c.func)
            FUNC_PUT: begin
                if (c.char_code == CHAR_NEWLINE) begin
                    shadow_cursor = (shadow_cursor / cols + 1) * cols;
                    typed_count   = 0;
                end else begin
                    shadow_cells[shadow_cursor] = c.char_code;
                    shadow_cursor++;
                    if (typed_count < LINE_MAX) typed_count++;
                end
                if (shadow_cursor >= total) begin
                    // move rows up one, blank the bottom row
                    for (int i = 0; i < total - cols; i++)
                        shadow_cells[i] = shadow_cells[i + cols];
                    for (int i = total - cols; i < total; i++)
                        shadow_cells[i] = CHAR_SPACE;
                    shadow_cursor = (nrows - 1) * cols;
                    r.scrolled    = 1'b1;
                end
            end
            FUNC_BACKSPACE: begin
                if (typed_count != 0 && shadow_cursor != 0) begin
                    typed_count--;
                    shadow_cursor--;
                    shadow_cells[shadow_cursor] = CHAR_SPACE;
                end
            end
            FUNC_CLEAR: blank_screen();
            default: r.read_char = (c.cell_index < total) ? shadow_cells[c.cell_index]
                                                          : CHAR_SPACE;
        endcase
        r.cursor_position = 13'(shadow_cursor);
        return r;
    endfunction

    function automatic void queue_cmd(logic [1:0] f, logic [7:0] ch, logic [12:0] idx);
        t_in c;
        c.func       = f;
        c.char_code  = ch;
        c.cell_index = idx;
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || !o_busy) begin
            if (i_start) begin
                expected_q.insert(expected_q.size(), console_step(i_cmd));
                n_sent++;
                if (i_cmd.func == FUNC_READ) n_reads++;
            end
            if (cmd_q.size() != 0 && (no_gaps || $urandom_range(99) >= 21)) begin
                i_start <= 1'b1;
                i_cmd   <= cmd_q.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: %p", o_result);
                n_fail++;
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (o_result.scrolled) n_scrolls++;
                if (o_result.read_char !== want.read_char) begin
                    $error("read_char mismatch: expected %02h, got %02h",
                           want.read_char, o_result.read_char);
                    n_fail++;
                end
                if (o_result.cursor_position !== want.cursor_position) begin
                    $error("cursor_position mismatch: expected %0d, got %0d",
                           want.cursor_position, o_result.cursor_position);
                    n_fail++;
                end
                if (o_result.scrolled !== want.scrolled) begin
                    $error("scrolled mismatch: expected %0b, got %0b",
                           want.scrolled, o_result.scrolled);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || i_start || expected_q.size() != 0 || o_busy);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        console_write_reg(idx, data);
        n_reg_wr++;
        @(negedge i_clk);
    endtask

    task automatic resize(logic [7:0] cols, logic [7:0] nrows);
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, nrows);
    endtask

    // mostly typing with random bytes, some edits, reads and rare clears
    task automatic random_phase(int n, int clear_pct);
        int unsigned total;
        int          pick;
        logic [1:0]  f;
        logic [7:0]  ch;
        logic [12:0] idx;
        total = eff_columns() * eff_rows();
        repeat (n) begin
            pick = $urandom_range(99);
            ch   = 8'($urandom_range(255));
            idx  = 13'($urandom_range(CELL_COUNT - 1));
            if (pick < clear_pct) begin
                f = FUNC_CLEAR;
            end else if (pick < clear_pct + 15) begin
                f = FUNC_BACKSPACE;
            end else if (pick < clear_pct + 35) begin
                f = FUNC_READ;
                if ($urandom_range(3) != 0) idx = 13'($urandom_range(total - 1));
            end else begin
                f = FUNC_PUT;
                if ($urandom_range(9) == 0) ch = CHAR_NEWLINE;
            end
            queue_cmd(f, ch, idx);
        end
    endtask

    initial begin
        columns_reg   = RST_COLUMNS;
        rows_reg      = RST_ROWS;
        typed_count   = 0;
        blank_screen();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_quiet();

        // reset geometry, 80x25
        queue_cmd(FUNC_BACKSPACE, 8'h00, 13'd0);
        queue_cmd(FUNC_READ,      8'hFF, 13'd0);
        queue_cmd(FUNC_PUT,       8'h00, 13'h1FFF);
        queue_cmd(FUNC_PUT,       8'hFF, 13'd0);
        queue_cmd(FUNC_PUT,       8'h41, 13'd0);
        queue_cmd(FUNC_BACKSPACE, 8'h00, 13'd0);
        queue_cmd(FUNC_READ,      8'h00, 13'd1);
        queue_cmd(FUNC_PUT,       CHAR_NEWLINE, 13'd0);
        queue_cmd(FUNC_BACKSPACE, 8'h00, 13'd0);
        queue_cmd(FUNC_PUT,       8'h55, 13'd0);
        queue_cmd(FUNC_PUT,       8'hAA, 13'd0);
        queue_cmd(FUNC_READ,      8'h00, 13'h1FFF);
        queue_cmd(FUNC_READ,      8'h00, 13'd1999);
        queue_cmd(FUNC_READ,      8'h00, 13'd2000);
        queue_cmd(FUNC_READ,      8'h00, 13'd80);
        queue_cmd(FUNC_CLEAR,     8'h00, 13'd0);
        // line still counted after clear, but cursor is home
        queue_cmd(FUNC_BACKSPACE, 8'h00, 13'd0);
        queue_cmd(FUNC_READ,      8'h00, 13'd80);
        queue_cmd(FUNC_READ,      8'h00, 13'd1);
        wait_quiet();
        random_phase(250, 1);

        // zero values act as one: 1x1, every put scrolls
        resize(8'd0, 8'd0);
        queue_cmd(FUNC_PUT,       8'h78, 13'd0);
        queue_cmd(FUNC_READ,      8'h00, 13'd0);
        queue_cmd(FUNC_PUT,       CHAR_NEWLINE, 13'd0);
        queue_cmd(FUNC_BACKSPACE, 8'h00, 13'd0);
        random_phase(150, 2);

        resize(8'd4, 8'd1);
        random_phase(200, 2);

        // oversize values clamp to the full 128x64 store
        resize(8'hFF, 8'hFF);
        queue_cmd(FUNC_PUT,  8'h7E, 13'd0);
        queue_cmd(FUNC_READ, 8'h00, 13'd0);
        repeat (64) queue_cmd(FUNC_PUT, CHAR_NEWLINE, 13'd0);
        queue_cmd(FUNC_READ,  8'h00, 13'h1FFF);
        queue_cmd(FUNC_READ,  8'h00, 13'd0);
        queue_cmd(FUNC_CLEAR, 8'h00, 13'd0);
        random_phase(60, 0);

        resize(8'd8, 8'd4);
        wait_quiet();
        no_gaps = 1'b1;
        random_phase(450, 2);
        wait_quiet();
        no_gaps = 1'b0;

        resize(8'd128, 8'd2);
        random_phase(250, 2);

        resize(8'd1, 8'd64);
        random_phase(200, 2);

        resize(8'd13, 8'd7);
        write_reg(REG_SPARE_A, 8'h5A);
        write_reg(REG_SPARE_B, 8'hA5);
        random_phase(300, 3);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        $display("summary: %0d commands (%0d reads) checked %0d results, %0d scrolls,",
                 n_sent, n_reads, n_checked, n_scrolls);
        $display("summary: %0d register writes across 8 geometries incl. 1x1 and 128x64",
                 n_reg_wr);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
